FILE: rtl/campose_pkg.sv
// Shared constants, types and tables for the camera pose update block.
`timescale 1ns / 1ps

package campose_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // angle and CORDIC x, y, z width (angle in radians * 2^30 reaches 2^33)
  localparam int ANG_W = 34;
  localparam logic [ANG_W-1:0] HALF_PI_Q30 = 34'd1686629712;
  localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 34;
  localparam int PROD_W = MUL_A_W + MUL_B_W;

  // request codes
  localparam logic [2:0] REQ_FWD    = 3'd0;
  localparam logic [2:0] REQ_BACK   = 3'd1;
  localparam logic [2:0] REQ_RIGHT  = 3'd2;
  localparam logic [2:0] REQ_LEFT   = 3'd3;
  localparam logic [2:0] REQ_RELOAD = 3'd4;

  // register indexes
  localparam logic [3:0] CFG_WALK_RATE   = 4'd0;
  localparam logic [3:0] CFG_TURN_SPEED  = 4'd1;
  localparam logic [3:0] CFG_START_POS_X = 4'd2;
  localparam logic [3:0] CFG_START_POS_Y = 4'd3;
  localparam logic [3:0] CFG_START_DIR_X = 4'd4;
  localparam logic [3:0] CFG_START_DIR_Y = 4'd5;
  localparam logic [3:0] CFG_START_PL_X  = 4'd6;
  localparam logic [3:0] CFG_START_PL_Y  = 4'd7;

  typedef struct packed {
    logic             start;
    logic             left;
    logic [ANG_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] cos;
    logic signed [ANG_W-1:0] sin;
  } cordic_sts_t;

  // atan(2^-i) * 2^30, truncated
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/campose_cordic.sv
// Quadrant reduction and iterative rotation-mode CORDIC giving cos and sin in Q.30.
`timescale 1ns / 1ps

module campose_cordic (
  input  logic                      clk,
  input  logic                      rst_n,
  input  campose_pkg::cordic_req_t  req,
  output campose_pkg::cordic_sts_t  sts
);
  import campose_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_QRED = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_MAP  = 2'd3;

  logic [1:0]              state_r;
  logic [ANG_W-1:0]        ang_r;
  logic [1:0]              quad_r;
  logic                    left_r;
  logic signed [ANG_W-1:0] x_r, y_r, z_r;
  logic [STEP_W-1:0]       step_r;
  logic signed [ANG_W-1:0] cos_r, sin_r;
  logic                    done_r;

  logic signed [ANG_W-1:0] dx, dy, t;
  logic signed [ANG_W-1:0] c_map, s_map;

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign t  = atan_q30(5'(step_r));

  always_comb begin
    case (quad_r)
      2'd1: begin
        c_map = -y_r;
        s_map = x_r;
      end
      2'd2: begin
        c_map = -x_r;
        s_map = -y_r;
      end
      2'd3: begin
        c_map = y_r;
        s_map = -x_r;
      end
      default: begin
        c_map = x_r;
        s_map = y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        C_IDLE: begin
          if (req.start) begin
            ang_r   <= req.angle;
            left_r  <= req.left;
            quad_r  <= 2'd0;
            state_r <= C_QRED;
          end
        end
        C_QRED: begin
          // strip one quarter turn a cycle
          if (ang_r >= HALF_PI_Q30) begin
            ang_r  <= ang_r - HALF_PI_Q30;
            quad_r <= quad_r + 2'd1;
          end else begin
            x_r     <= GAIN_Q30;
            y_r     <= '0;
            z_r     <= signed'(ang_r);
            step_r  <= '0;
            state_r <= C_ITER;
          end
        end
        C_ITER: begin
          if (!z_r[ANG_W-1]) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - t;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + t;
          end
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
            state_r <= C_MAP;
          end
        end
        C_MAP: begin
          cos_r   <= c_map;
          sin_r   <= left_r ? -s_map : s_map;
          done_r  <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign sts = '{done: done_r, cos: cos_r, sin: sin_r};

endmodule

FILE: rtl/camera_pose_update_top.sv
// Top level of the camera pose update block: registers, sequencer and shared multiplier.
`timescale 1ns / 1ps

// Camera pose keeper for a raycaster. Each input word carries a request in in_tuser
// (forward, backward, rotate right, rotate left, reload start pose) and a Q0.16 time
// step in in_tdata; each returns exactly one output word with the updated pose and a
// saturation flag. One request is in flight at a time and in_tready is low while it
// runs. All products go through a single registered 17x34 multiplier. A move takes
// three multiplier passes. A rotation takes one to six quarter-turn reduction steps,
// one CORDIC iteration per cycle, and eight multiplier passes to turn both vectors.
// in_tready returns in the same cycle as out_tvalid rises. A finished word waits in
// the output register; the next request is taken once it has moved there, so a
// stalled output word adds its wait. The configuration port is always ready; the user
// must write it only while no request runs, and the block itself does not enforce it.

module camera_pose_update_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [15:0] time_step
  input  logic [2:0]   in_tuser,   // [2:0] req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] out_pos_x, [63:32] out_pos_y,
                                   // [79:64] out_dir_x, [95:80] out_dir_y,
                                   // [111:96] out_plane_x, [127:112] out_plane_y
  output logic [0:0]   out_tuser,  // [0] pos_saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import campose_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MK   = 4'd1;
  localparam logic [3:0] S_MX   = 4'd2;
  localparam logic [3:0] S_MY   = 4'd3;
  localparam logic [3:0] S_MF   = 4'd4;
  localparam logic [3:0] S_AK   = 4'd5;
  localparam logic [3:0] S_CS   = 4'd6;
  localparam logic [3:0] S_CW   = 4'd7;
  localparam logic [3:0] S_RT   = 4'd8;
  localparam logic [3:0] S_CM   = 4'd9;
  localparam logic [3:0] S_LD   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // configuration
  logic [15:0]        walk_rate_r, turn_speed_r;
  logic signed [31:0] start_pos_x_r, start_pos_y_r;
  logic signed [15:0] start_dir_x_r, start_dir_y_r, start_pl_x_r, start_pl_y_r;

  // pose
  logic signed [31:0] pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, pl_x_r, pl_y_r;

  // sequencer and datapath
  logic [3:0]                state_r;
  logic [2:0]                req_r;
  logic [15:0]               ts_r;
  logic                      sat_r;
  logic [3:0]                cnt_r;
  logic signed [MUL_B_W-1:0] k_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [15:0]        nvec_r [4];

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  // output register
  logic         out_tvalid_r;
  logic [127:0] out_tdata_r;
  logic         out_sat_r;
  logic         out_load;

  cordic_req_t cor_req;
  cordic_sts_t cor_sts;

  campose_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .sts   (cor_sts)
  );

  assign cor_req = '{start: (state_r == S_CS),
                     left:  (req_r == REQ_LEFT),
                     angle: {prod_r[32:0], 1'b0}};

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_sat_r;

  // load the output register when the finished word can move there
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // rotation pass select
  logic signed [15:0] rt_vx, rt_vy;
  assign rt_vx = cnt_r[2] ? pl_x_r : dir_x_r;
  assign rt_vy = cnt_r[2] ? pl_y_r : dir_y_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MK: begin
        mul_a = signed'({1'b0, walk_rate_r});
        mul_b = signed'({18'd0, ts_r});
      end
      S_MX: begin
        mul_a = MUL_A_W'(dir_x_r);
        mul_b = signed'({2'b00, prod_r[31:0]});
      end
      S_MY: begin
        mul_a = MUL_A_W'(dir_y_r);
        mul_b = k_r;
      end
      S_AK: begin
        mul_a = signed'({1'b0, turn_speed_r});
        mul_b = signed'({18'd0, ts_r});
      end
      S_RT: begin
        case (cnt_r[1:0])
          2'd0: begin
            mul_a = MUL_A_W'(rt_vx);
            mul_b = cor_sts.cos;
          end
          2'd1: begin
            mul_a = MUL_A_W'(rt_vy);
            mul_b = cor_sts.sin;
          end
          2'd2: begin
            mul_a = MUL_A_W'(rt_vx);
            mul_b = cor_sts.sin;
          end
          default: begin
            mul_a = MUL_A_W'(rt_vy);
            mul_b = cor_sts.cos;
          end
        endcase
      end
      default: ;
    endcase
  end

  // move: round the product to Q16.16, add and clamp
  logic signed [PROD_W-1:0] mv_rnd;
  logic signed [30:0]       mv_d;
  logic signed [33:0]       mv_step, mv_sum;
  logic signed [31:0]       mv_pos, mv_val;
  logic                     mv_ovf;

  assign mv_rnd  = prod_r + PROD_W'(21'sd524288);
  assign mv_d    = mv_rnd[50:20];
  assign mv_pos  = (state_r == S_MY) ? pos_x_r : pos_y_r;
  assign mv_step = (req_r == REQ_BACK) ? -34'(mv_d) : 34'(mv_d);
  assign mv_sum  = 34'(mv_pos) + mv_step;
  assign mv_ovf  = (mv_sum[33:31] != 3'b000) && (mv_sum[33:31] != 3'b111);
  assign mv_val  = !mv_ovf ? mv_sum[31:0] : (mv_sum[33] ? 32'sh80000000 : 32'sh7FFFFFFF);

  // rotate: combine two products, round to Q4.12 and clamp
  logic [2:0]         rt_p;
  logic signed [51:0] rt_sum, rt_rnd;
  logic signed [21:0] rt_q;
  logic signed [15:0] rt_val;

  assign rt_p   = 3'(cnt_r - 4'd1);
  assign rt_sum = rt_p[1] ? (52'(acc_r) + 52'(prod_r)) : (52'(acc_r) - 52'(prod_r));
  assign rt_rnd = rt_sum + 52'sd536870912;
  assign rt_q   = rt_rnd[51:30];
  assign rt_val = ((rt_q[21:15] == 7'h00) || (rt_q[21:15] == 7'h7F)) ? rt_q[15:0] :
                  (rt_q[21] ? 16'sh8000 : 16'sh7FFF);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_rate_r   <= 16'd1280;
      turn_speed_r  <= 16'd24576;
      start_pos_x_r <= '0;
      start_pos_y_r <= '0;
      start_dir_x_r <= 16'sd4096;
      start_dir_y_r <= '0;
      start_pl_x_r  <= '0;
      start_pl_y_r  <= 16'sd2703;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WALK_RATE:   walk_rate_r   <= cfg_data[15:0];
        CFG_TURN_SPEED:  turn_speed_r  <= cfg_data[15:0];
        CFG_START_POS_X: start_pos_x_r <= cfg_data;
        CFG_START_POS_Y: start_pos_y_r <= cfg_data;
        CFG_START_DIR_X: start_dir_x_r <= cfg_data[15:0];
        CFG_START_DIR_Y: start_dir_y_r <= cfg_data[15:0];
        CFG_START_PL_X:  start_pl_x_r  <= cfg_data[15:0];
        CFG_START_PL_Y:  start_pl_y_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
      dir_x_r      <= 16'sd4096;
      dir_y_r      <= '0;
      pl_x_r       <= '0;
      pl_y_r       <= 16'sd2703;
      out_tvalid_r <= 1'b0;
      sat_r        <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r <= in_tuser;
            ts_r  <= in_tdata;
            sat_r <= 1'b0;
            case (in_tuser)
              REQ_FWD, REQ_BACK:   state_r <= S_MK;
              REQ_RIGHT, REQ_LEFT: state_r <= S_AK;
              REQ_RELOAD:          state_r <= S_LD;
              default:             state_r <= S_OUT;
            endcase
          end
        end
        S_MK: state_r <= S_MX;
        S_MX: begin
          k_r     <= signed'({2'b00, prod_r[31:0]});
          state_r <= S_MY;
        end
        S_MY: begin
          pos_x_r <= mv_val;
          sat_r   <= sat_r | mv_ovf;
          state_r <= S_MF;
        end
        S_MF: begin
          pos_y_r <= mv_val;
          sat_r   <= sat_r | mv_ovf;
          state_r <= S_OUT;
        end
        S_AK: state_r <= S_CS;
        S_CS: state_r <= S_CW;
        S_CW: begin
          if (cor_sts.done) begin
            cnt_r   <= '0;
            state_r <= S_RT;
          end
        end
        S_RT: begin
          // product of pass cnt-1 is in prod_r now
          if (cnt_r != 4'd0) begin
            if (!rt_p[0]) begin
              acc_r <= prod_r;
            end else begin
              nvec_r[rt_p[2:1]] <= rt_val;
            end
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd8) begin
            state_r <= S_CM;
          end
        end
        S_CM: begin
          dir_x_r <= nvec_r[0];
          dir_y_r <= nvec_r[1];
          pl_x_r  <= nvec_r[2];
          pl_y_r  <= nvec_r[3];
          state_r <= S_OUT;
        end
        S_LD: begin
          pos_x_r <= start_pos_x_r;
          pos_y_r <= start_pos_y_r;
          dir_x_r <= start_dir_x_r;
          dir_y_r <= start_dir_y_r;
          pl_x_r  <= start_pl_x_r;
          pl_y_r  <= start_pl_y_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {pl_y_r, pl_x_r, dir_y_r, dir_x_r, pos_y_r, pos_x_r};
      out_sat_r   <= sat_r;
    end
  end

endmodule

FILE: rtl/campose_chk.sv
// Port-level assertions for the camera pose update block, bound to the top level.
`timescale 1ns / 1ps

module campose_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // one request at a time: drop ready after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is running");

  // a new result only appears at the end of a request
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a running request");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (in_tready || !rst_n))
    else $error("block not idle after reset");

endmodule

bind camera_pose_update_top campose_chk u_campose_chk (.*);
